### rtl/gfgd_pkg.sv
`default_nettype none
package gfgd_pkg;

    localparam int unsigned TIME_W = 32;
    localparam int unsigned RATE_W = 16;
    localparam int unsigned AXIS_W = RATE_W + 1;

    localparam logic [TIME_W-1:0] POLL_GAP_MS   = 32'd50;
    localparam logic [TIME_W-1:0] SETTLE_MS     = 32'd300;
    localparam logic [TIME_W-1:0] REFRACTORY_MS = 32'd600;

    localparam logic signed [AXIS_W-1:0] TRIG_360_LSB = 17'sd23040;
    localparam logic signed [AXIS_W-1:0] TRIG_270_LSB = 17'sd17280;
    localparam logic signed [AXIS_W-1:0] TRIG_180_LSB = 17'sd11520;
    localparam logic signed [AXIS_W-1:0] RELEASE_LSB  = 17'sd3200;

    localparam logic [1:0] REG_ORIENTATION  = 2'd0;
    localparam logic [1:0] REG_GESTURE_MODE = 2'd1;
    localparam logic [1:0] REG_SENSITIVITY  = 2'd2;

    localparam logic [1:0] ORIENT_POS_X = 2'd0;
    localparam logic [1:0] ORIENT_NEG_Y = 2'd1;
    localparam logic [1:0] ORIENT_NEG_X = 2'd2;
    localparam logic [1:0] ORIENT_POS_Y = 2'd3;

    localparam logic [1:0] MODE_OFF      = 2'd0;
    localparam logic [1:0] MODE_INVERTED = 2'd2;

    localparam logic [1:0] SENS_360 = 2'd0;
    localparam logic [1:0] SENS_270 = 2'd1;

    typedef enum logic [1:0] {
        GEST_NONE = 2'd0,
        GEST_NEXT = 2'd1,
        GEST_PREV = 2'd2
    } t_gesture;

    typedef struct packed {
        logic [1:0] orientation;
        logic [1:0] gesture_mode;
        logic [1:0] sensitivity;
    } t_cfg;

    typedef struct packed {
        logic [TIME_W-1:0] last_poll_time;
        logic              armed;
        logic [TIME_W-1:0] arm_time;
        logic [TIME_W-1:0] last_gesture_time;
        logic              gesture_active;
    } t_state;

endpackage
`default_nettype wire

### rtl/gyro_flip_gesture_detector_core.sv
// Gyro flip gesture detector. Each transfer on the input channel carries one
// gyro sample with its millisecond timestamp and produces exactly one gesture
// code (none, next or previous) on the output channel, in order. A sample is
// registered in the input register on arrival and evaluated against the
// detector state once the output register can take the result; the state
// and the output register are updated in that same cycle, so one sample per
// clock is sustained while the output is not stalled. The output register
// holds a result while the output stalls and the input register keeps taking
// samples until both registers are full. Configuration writes are taken at
// any time and must only be issued while no samples are in flight.
`default_nettype none
module gyro_flip_gesture_detector_core
    import gfgd_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    output      logic                     o_stall,
    input  wire logic [TIME_W-1:0]        i_time_ms,
    input  wire logic signed [RATE_W-1:0] i_rate_x,
    input  wire logic signed [RATE_W-1:0] i_rate_y,
    input  wire logic                     i_sample_ok,
    output      logic                     o_valid,
    input  wire logic                     i_stall,
    output      logic [1:0]               o_gesture,
    input  wire logic                     i_cfg_valid,
    output      logic                     o_cfg_ready,
    input  wire logic [1:0]               i_cfg_index,
    input  wire logic [1:0]               i_cfg_data
);

    t_cfg     cfg;
    t_state   r_state;
    t_state   n_state;
    t_gesture n_gesture;

    logic                     r_in_vld;
    logic [TIME_W-1:0]        r_time_ms;
    logic signed [RATE_W-1:0] r_rate_x;
    logic signed [RATE_W-1:0] r_rate_y;
    logic                     r_sample_ok;
    logic                     r_out_vld;
    t_gesture                 r_gesture;

    logic advance;
    logic in_load;

    gfgd_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_cfg       (cfg)
    );

    gfgd_eval u_eval (
        .i_cfg       (cfg),
        .i_state     (r_state),
        .i_time_ms   (r_time_ms),
        .i_rate_x    (r_rate_x),
        .i_rate_y    (r_rate_y),
        .i_sample_ok (r_sample_ok),
        .o_state     (n_state),
        .o_gesture   (n_gesture)
    );

    assign advance   = r_in_vld && (!r_out_vld || !i_stall);
    assign o_stall   = r_in_vld && !advance;
    assign in_load   = i_valid && !o_stall;
    assign o_valid   = r_out_vld;
    assign o_gesture = r_gesture;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_state   <= '0;
        end else begin
            if (in_load) begin
                r_in_vld <= 1'b1;
            end else if (advance) begin
                r_in_vld <= 1'b0;
            end
            if (advance) begin
                r_out_vld <= 1'b1;
                r_state   <= n_state;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load) begin
            r_time_ms   <= i_time_ms;
            r_rate_x    <= i_rate_x;
            r_rate_y    <= i_rate_y;
            r_sample_ok <= i_sample_ok;
        end
        if (advance) begin
            r_gesture <= n_gesture;
        end
    end

endmodule
`default_nettype wire

### rtl/gfgd_cfg_regs.sv
`default_nettype none
module gfgd_cfg_regs
    import gfgd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_valid,
    input  wire logic [1:0] i_cfg_index,
    input  wire logic [1:0] i_cfg_data,
    output      logic       o_cfg_ready,
    output      t_cfg       o_cfg
);

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.orientation  <= ORIENT_POS_X;
            r_cfg.gesture_mode <= MODE_OFF;
            r_cfg.sensitivity  <= SENS_270;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_ORIENTATION:  r_cfg.orientation  <= i_cfg_data;
                REG_GESTURE_MODE: r_cfg.gesture_mode <= i_cfg_data;
                REG_SENSITIVITY:  r_cfg.sensitivity  <= i_cfg_data;
                default: ;
            endcase
        end
    end

endmodule
`default_nettype wire

### rtl/gfgd_eval.sv
`default_nettype none
module gfgd_eval
    import gfgd_pkg::*;
(
    input  wire t_cfg                      i_cfg,
    input  wire t_state                    i_state,
    input  wire logic [TIME_W-1:0]         i_time_ms,
    input  wire logic signed [RATE_W-1:0]  i_rate_x,
    input  wire logic signed [RATE_W-1:0]  i_rate_y,
    input  wire logic                      i_sample_ok,
    output      t_state                    o_state,
    output      t_gesture                  o_gesture
);

    logic                     mode_off;
    logic [TIME_W-1:0]        poll_dt;
    logic [TIME_W-1:0]        arm_eff;
    logic [TIME_W-1:0]        lgt_eff;
    logic [TIME_W-1:0]        settle_dt;
    logic [TIME_W-1:0]        refr_dt;
    logic signed [AXIS_W-1:0] sel_axis;
    logic signed [AXIS_W-1:0] axis;
    logic signed [AXIS_W-1:0] mag;
    logic signed [AXIS_W-1:0] thr;

    always_comb begin
        case (i_cfg.orientation)
            ORIENT_NEG_Y: sel_axis = -AXIS_W'(i_rate_y);
            ORIENT_NEG_X: sel_axis = -AXIS_W'(i_rate_x);
            ORIENT_POS_Y: sel_axis = AXIS_W'(i_rate_y);
            default:      sel_axis = AXIS_W'(i_rate_x);
        endcase
        axis = (i_cfg.gesture_mode == MODE_INVERTED) ? -sel_axis : sel_axis;
        mag  = axis[AXIS_W-1] ? -axis : axis;

        case (i_cfg.sensitivity)
            SENS_360: thr = TRIG_360_LSB;
            SENS_270: thr = TRIG_270_LSB;
            default:  thr = TRIG_180_LSB;
        endcase
    end

    always_comb begin
        mode_off  = (i_cfg.gesture_mode == MODE_OFF);
        poll_dt   = i_time_ms - i_state.last_poll_time;
        arm_eff   = i_state.armed ? i_state.arm_time : i_time_ms;
        lgt_eff   = i_state.armed ? i_state.last_gesture_time : i_time_ms;
        settle_dt = i_time_ms - arm_eff;
        refr_dt   = i_time_ms - lgt_eff;

        o_state   = i_state;
        o_gesture = GEST_NONE;

        if (mode_off && !i_state.armed) begin
            o_state = i_state;
        end else if ((i_state.last_poll_time != '0) && (poll_dt < POLL_GAP_MS)) begin
            o_state = i_state;
        end else begin
            o_state.last_poll_time    = i_time_ms;
            o_state.armed             = 1'b1;
            o_state.arm_time          = arm_eff;
            o_state.last_gesture_time = lgt_eff;
            if (mode_off) begin
                o_state.armed          = 1'b0;
                o_state.gesture_active = 1'b0;
            end else if (i_sample_ok && (settle_dt >= SETTLE_MS)) begin
                if (i_state.gesture_active) begin
                    if (mag < RELEASE_LSB) begin
                        o_state.gesture_active = 1'b0;
                    end
                end else if (refr_dt >= REFRACTORY_MS) begin
                    if (axis > thr) begin
                        o_state.gesture_active    = 1'b1;
                        o_state.last_gesture_time = i_time_ms;
                        o_gesture                 = GEST_NEXT;
                    end else if (axis < -thr) begin
                        o_state.gesture_active    = 1'b1;
                        o_state.last_gesture_time = i_time_ms;
                        o_gesture                 = GEST_PREV;
                    end
                end
            end
        end
    end

endmodule
`default_nettype wire

### tb/gfgd_gesture_checker.sv
`timescale 1ns / 1ps
module gfgd_gesture_checker
    import gfgd_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_in_valid,
    input  wire logic                     i_in_stall,
    input  wire logic [TIME_W-1:0]        i_time_ms,
    input  wire logic signed [RATE_W-1:0] i_rate_x,
    input  wire logic signed [RATE_W-1:0] i_rate_y,
    input  wire logic                     i_sample_ok,
    input  wire logic                     i_out_valid,
    input  wire logic                     i_out_stall,
    input  wire logic [1:0]               i_gesture,
    input  wire logic                     i_cfg_valid,
    input  wire logic                     i_cfg_ready,
    input  wire logic [1:0]               i_cfg_index,
    input  wire logic [1:0]               i_cfg_data,
    output int                            o_errors,
    output int                            o_pending,
    output int                            o_checked,
    output int                            o_fired
);

    logic [1:0]        cfg_orient;
    logic [1:0]        cfg_mode;
    logic [1:0]        cfg_sens;

    logic [TIME_W-1:0] poll_ms;
    logic              is_armed;
    logic [TIME_W-1:0] armed_ms;
    logic [TIME_W-1:0] gesture_ms;
    logic              in_gesture;

    t_gesture          expected_gestures[$];
    t_gesture          predicted;
    t_gesture          wanted;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t ns: %s", $time, msg);
        o_errors++;
    endtask

    task automatic detect_flip(
        input  logic [TIME_W-1:0]        now,
        input  logic signed [RATE_W-1:0] rx,
        input  logic signed [RATE_W-1:0] ry,
        input  logic                     ok,
        output t_gesture                 g
    );
        logic signed [AXIS_W-1:0] gx;
        logic signed [AXIS_W-1:0] gy;
        logic signed [AXIS_W-1:0] axis;
        logic signed [AXIS_W-1:0] mag;
        logic signed [AXIS_W-1:0] thr;
        g = GEST_NONE;
        if (cfg_mode == MODE_OFF && !is_armed) return;
        if (poll_ms != '0 && (now - poll_ms) < POLL_GAP_MS) return;
        poll_ms = now;
        if (!is_armed) begin
            is_armed   = 1'b1;
            armed_ms   = now;
            gesture_ms = now;
        end
        if (cfg_mode == MODE_OFF) begin
            is_armed   = 1'b0;
            in_gesture = 1'b0;
            return;
        end
        if (!ok) return;
        if ((now - armed_ms) < SETTLE_MS) return;

        gx = AXIS_W'(rx);
        gy = AXIS_W'(ry);
        case (cfg_orient)
            ORIENT_NEG_Y: axis = -gy;
            ORIENT_NEG_X: axis = -gx;
            ORIENT_POS_Y: axis = gy;
            default:      axis = gx;
        endcase
        if (cfg_mode == MODE_INVERTED) axis = -axis;

        if (cfg_sens == SENS_360) thr = TRIG_360_LSB;
        else if (cfg_sens == SENS_270) thr = TRIG_270_LSB;
        else thr = TRIG_180_LSB;

        if (in_gesture) begin
            mag = (axis < 0) ? -axis : axis;
            if (mag < RELEASE_LSB) in_gesture = 1'b0;
            return;
        end
        if ((now - gesture_ms) < REFRACTORY_MS) return;
        if (axis > thr) begin
            in_gesture = 1'b1;
            gesture_ms = now;
            g = GEST_NEXT;
        end else if (axis < -thr) begin
            in_gesture = 1'b1;
            gesture_ms = now;
            g = GEST_PREV;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_orient = ORIENT_POS_X;
            cfg_mode   = MODE_OFF;
            cfg_sens   = SENS_270;
            poll_ms    = '0;
            is_armed   = 1'b0;
            armed_ms   = '0;
            gesture_ms = '0;
            in_gesture = 1'b0;
            expected_gestures.delete();
            o_errors   = 0;
            o_checked  = 0;
            o_fired    = 0;
            o_pending <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_ORIENTATION:  cfg_orient = i_cfg_data;
                    REG_GESTURE_MODE: cfg_mode   = i_cfg_data;
                    REG_SENSITIVITY:  cfg_sens   = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                detect_flip(i_time_ms, i_rate_x, i_rate_y, i_sample_ok, predicted);
                expected_gestures.push_back(predicted);
                if (predicted != GEST_NONE) o_fired++;
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_gestures.size() == 0) begin
                    report_mismatch($sformatf("gesture %0d with no sample outstanding",
                                              i_gesture));
                end else begin
                    wanted = expected_gestures.pop_front();
                    if (i_gesture !== wanted) begin
                        report_mismatch($sformatf("result %0d: gesture %0d, expected %0d",
                                                  o_checked, i_gesture, wanted));
                    end
                    o_checked++;
                end
            end
            o_pending <= expected_gestures.size();
        end
    end

endmodule

### tb/tb_gyro_flip_gesture_detector_core.sv
`timescale 1ns / 1ps
module tb_gyro_flip_gesture_detector_core;
    import gfgd_pkg::*;

    localparam logic [1:0] MODE_NORMAL = 2'd1;
    localparam logic [1:0] MODE_ALIAS  = 2'd3;
    localparam logic [1:0] SENS_180    = 2'd2;
    localparam logic [1:0] SENS_ALIAS  = 2'd3;
    localparam logic [1:0] REG_SPARE   = 2'd3;
    localparam int HOLD_CYCLES    = 80;
    localparam int RANDOM_SAMPLES = 400;
    localparam int PRESSURE_PHASE = 1;

    logic                     i_clk       = 1'b0;
    logic                     i_rst_n     = 1'b0;
    logic                     i_valid     = 1'b0;
    logic                     o_stall;
    logic [TIME_W-1:0]        i_time_ms   = '0;
    logic signed [RATE_W-1:0] i_rate_x    = '0;
    logic signed [RATE_W-1:0] i_rate_y    = '0;
    logic                     i_sample_ok = 1'b0;
    logic                     o_valid;
    logic                     i_stall     = 1'b0;
    logic [1:0]               o_gesture;
    logic                     i_cfg_valid = 1'b0;
    logic                     o_cfg_ready;
    logic [1:0]               i_cfg_index = '0;
    logic [1:0]               i_cfg_data  = '0;

    int errors;
    int pending;
    int checked;
    int fired;

    bit calm_tx;
    bit calm_rx;
    bit hold_request;
    int samples_sent;
    int settings_used;
    logic [TIME_W-1:0] now_ms;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    gyro_flip_gesture_detector_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_time_ms   (i_time_ms),
        .i_rate_x    (i_rate_x),
        .i_rate_y    (i_rate_y),
        .i_sample_ok (i_sample_ok),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_gesture   (o_gesture),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    gfgd_gesture_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .i_in_stall  (o_stall),
        .i_time_ms   (i_time_ms),
        .i_rate_x    (i_rate_x),
        .i_rate_y    (i_rate_y),
        .i_sample_ok (i_sample_ok),
        .i_out_valid (o_valid),
        .i_out_stall (i_stall),
        .i_gesture   (o_gesture),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_checked   (checked),
        .o_fired     (fired)
    );

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 8);
        return $urandom_range(15, 40);
    endfunction

    function automatic logic signed [RATE_W-1:0] pick_rate();
        int m;
        case ($urandom_range(0, 9))
            0, 1, 2: m = $urandom_range(0, 3199);
            3:       m = 3199 + $urandom_range(0, 2);
            4: begin
                case ($urandom_range(0, 2))
                    0:       m = int'(TRIG_180_LSB);
                    1:       m = int'(TRIG_270_LSB);
                    default: m = int'(TRIG_360_LSB);
                endcase
                m = m + $urandom_range(0, 2) - 1;
            end
            5:       return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            6, 7:    m = $urandom_range(11521, 32767);
            default: return RATE_W'($urandom());
        endcase
        return RATE_W'($urandom_range(0, 1) ? -m : m);
    endfunction

    function automatic logic [TIME_W-1:0] pick_step();
        int r;
        r = $urandom_range(0, 99);
        if (r < 12) return $urandom_range(0, 49);
        if (r < 82) return $urandom_range(50, 250);
        if (r < 97) return $urandom_range(251, 800);
        return $urandom();
    endfunction

    task automatic send_sample(
        input logic [TIME_W-1:0]        stamp,
        input logic signed [RATE_W-1:0] rx,
        input logic signed [RATE_W-1:0] ry,
        input logic                     ok
    );
        int gap;
        gap = (calm_tx || $urandom_range(0, 1)) ? 0 : idle_len();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_time_ms   <= stamp;
        i_rate_x    <= rx;
        i_rate_y    <= ry;
        i_sample_ok <= ok;
        do @(posedge i_clk); while (o_stall);
        samples_sent++;
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic reconfigure(
        input logic [1:0] orient,
        input logic [1:0] mode,
        input logic [1:0] sens
    );
        wait_idle();
        write_reg(REG_ORIENTATION, orient);
        write_reg(REG_GESTURE_MODE, mode);
        write_reg(REG_SENSITIVITY, sens);
        settings_used++;
    endtask

    initial begin
        int   run;
        logic level;
        run   = 0;
        level = 1'b0;
        forever begin
            @(posedge i_clk);
            if (run == 0) begin
                if (hold_request) begin
                    level        = 1'b1;
                    run          = HOLD_CYCLES;
                    hold_request = 1'b0;
                end else if (calm_rx) begin
                    level = 1'b0;
                    run   = 1;
                end else begin
                    level = ($urandom_range(0, 2) == 0);
                    run   = idle_len();
                end
            end
            i_stall <= level;
            run = run - 1;
        end
    end

    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        int         counted;
        int         n;
        logic [1:0] mode;
        counted = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Disabled while idle, then arming at a zero timestamp.
        send_sample(32'd1000, 16'sh7FFF, 16'sd0, 1'b1);
        reconfigure(ORIENT_POS_X, MODE_NORMAL, SENS_360);
        write_reg(REG_SPARE, 2'd3);
        send_sample(32'd0, 16'sd0, 16'sd0, 1'b1);
        send_sample(32'd10, 16'sd0, 16'sd0, 1'b1);
        send_sample(32'd30, 16'sh7FFF, 16'sd0, 1'b1);
        send_sample(32'd310, 16'sh7FFF, 16'sd0, 1'b0);
        send_sample(32'd700, 16'sd23040, 16'sd0, 1'b1);
        send_sample(32'd760, 16'sd23041, 16'sd0, 1'b1);
        send_sample(32'd820, -16'sd32768, 16'sd0, 1'b1);
        send_sample(32'd880, 16'sd3200, 16'sd0, 1'b1);
        send_sample(32'd940, -16'sd3199, 16'sd0, 1'b1);
        send_sample(32'd1000, 16'sh7FFF, 16'sd0, 1'b1);
        send_sample(32'd1400, -16'sd23041, 16'sd0, 1'b1);
        send_sample(32'd1460, 16'sd0, 16'sd0, 1'b1);

        reconfigure(ORIENT_NEG_Y, MODE_INVERTED, SENS_ALIAS);
        send_sample(32'd2100, 16'sd0, -16'sd11521, 1'b1);
        send_sample(32'd2160, -16'sd32768, 16'sd0, 1'b1);

        reconfigure(ORIENT_POS_Y, MODE_ALIAS, SENS_270);
        send_sample(32'd2800, 16'sd0, 16'sd17281, 1'b1);
        send_sample(32'd2860, 16'sd0, 16'sd0, 1'b1);

        reconfigure(ORIENT_POS_Y, MODE_OFF, SENS_270);
        send_sample(32'd3000, 16'sh7FFF, 16'sh7FFF, 1'b1);
        send_sample(32'd3100, 16'sh7FFF, 16'sh7FFF, 1'b1);

        // Timestamps wrapping through zero.
        reconfigure(ORIENT_NEG_X, MODE_NORMAL, SENS_180);
        send_sample(32'hFFFF_FFF0, 16'sd0, 16'sd0, 1'b1);
        send_sample(32'h0000_0020, -16'sd32768, 16'sd0, 1'b1);
        send_sample(32'h0000_0030, 16'sd0, 16'sd0, 1'b1);
        send_sample(32'h0000_0200, -16'sd32768, 16'sd0, 1'b1);
        send_sample(32'h0000_0300, -16'sd32768, 16'sd0, 1'b1);
        send_sample(32'h0000_0360, 16'sh7FFF, 16'sh7FFF, 1'b1);

        now_ms = 32'h0000_1000;
        while (counted < RANDOM_SAMPLES) begin
            case ($urandom_range(0, 9))
                0:       mode = MODE_OFF;
                1:       mode = MODE_ALIAS;
                2, 3, 4, 5: mode = MODE_NORMAL;
                default: mode = MODE_INVERTED;
            endcase
            reconfigure(2'($urandom_range(0, 3)), mode, 2'($urandom_range(0, 3)));
            calm_tx = ($urandom_range(0, 4) == 0);
            calm_rx = ($urandom_range(0, 4) == 0);
            n = (mode == MODE_OFF) ? 6 : 40;
            if (settings_used == PRESSURE_PHASE + 6) begin
                calm_tx      = 1'b1;
                calm_rx      = 1'b0;
                hold_request = 1'b1;
                n            = 40;
                while (hold_request) @(posedge i_clk);
            end
            repeat (n) begin
                now_ms = now_ms + pick_step();
                send_sample(now_ms, pick_rate(), pick_rate(), $urandom_range(0, 9) != 0);
            end
            if (mode != MODE_OFF) counted += n;
        end

        wait_idle();
        repeat (6) @(posedge i_clk);
        $display("Sent %0d gyro samples under %0d register settings; %0d results checked,",
                 samples_sent, settings_used, checked);
        $display("of which %0d were next or previous gestures.", fired);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
